[src/lkh_pkg.sv]
// Shared types, constants and mix shift table for the lookup2 key hash block.
package lkh_pkg;

	localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;
	localparam int unsigned BLOCK_BYTES = 12;
	localparam int unsigned MIX_ROUNDS = 9;
	localparam int unsigned JOB_DEPTH = 4;

	typedef struct packed {
		logic [7:0] key_byte;
		logic       last_byte;
		logic       empty_key;
	} in_word_t;

	typedef struct packed {
		logic [31:0] hash_value;
		logic [7:0]  bucket_index;
	} out_word_t;

	// one gathered block or key tail handed from front to back
	typedef struct packed {
		logic [31:0] wa;
		logic [31:0] wb;
		logic [31:0] wc;
		logic [31:0] len;
		logic [31:0] seed;
		logic        blk;
		logic        fin;
		logic        first;
	} job_t;

	typedef enum logic [1:0] {
		TGT_A = 2'd0,
		TGT_B = 2'd1,
		TGT_C = 2'd2
	} mix_tgt_t;

	function automatic logic [4:0] mix_shift(input logic [3:0] rnd);
		logic [4:0] sh;
		case (rnd)
			4'd0: sh = 5'd13;
			4'd1: sh = 5'd8;
			4'd2: sh = 5'd13;
			4'd3: sh = 5'd12;
			4'd4: sh = 5'd16;
			4'd5: sh = 5'd5;
			4'd6: sh = 5'd3;
			4'd7: sh = 5'd10;
			4'd8: sh = 5'd15;
			default: sh = 5'd0;
		endcase
		return sh;
	endfunction

	function automatic mix_tgt_t mix_target(input logic [3:0] rnd);
		mix_tgt_t t;
		case (rnd)
			4'd0, 4'd3, 4'd6: t = TGT_A;
			4'd1, 4'd4, 4'd7: t = TGT_B;
			default:          t = TGT_C;
		endcase
		return t;
	endfunction

endpackage

[src/lkh_front.sv]
// Front end: packs key bytes into block words and emits one job per block or key end.
module lkh_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lkh_pkg::in_word_t in_word,
	input  logic            q_full,
	input  logic            cfg_wr_en,
	input  logic [31:0]     cfg_wr_data,
	output logic            job_push,
	output lkh_pkg::job_t   job
);

	logic [3:0]  pos_q;
	logic [31:0] wa_q, wb_q, wc_q, len_q;
	logic        first_q;
	logic [31:0] seed_q, key_seed_q;
	logic        key_open_q;

	logic        accept, has_byte, blk_end;
	logic [31:0] wa_n, wb_n, wc_n, len_n;
	logic [4:0]  lane_lsb;

	always_comb begin
		accept   = push && !q_full;
		has_byte = !in_word.empty_key;
		lane_lsb = {pos_q[1:0], 3'b000};
		wa_n     = wa_q;
		wb_n     = wb_q;
		wc_n     = wc_q;
		if (has_byte) begin
			case (pos_q[3:2])
				2'b00:   wa_n[lane_lsb +: 8] = in_word.key_byte;
				2'b01:   wb_n[lane_lsb +: 8] = in_word.key_byte;
				2'b10:   wc_n[lane_lsb +: 8] = in_word.key_byte;
				default: wa_n = wa_q;
			endcase
		end
		len_n    = len_q + {31'd0, has_byte};
		blk_end  = has_byte && (pos_q == 4'(lkh_pkg::BLOCK_BYTES - 1));
		job_push = accept && (blk_end || in_word.last_byte);
		job.wa    = wa_n;
		job.wb    = wb_n;
		job.wc    = wc_n;
		job.len   = len_n;
		// a key that already holds a byte keeps the seed it started with
		job.seed  = key_open_q ? key_seed_q : seed_q;
		job.blk   = blk_end;
		job.fin   = in_word.last_byte;
		job.first = first_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			wa_q       <= '0;
			wb_q       <= '0;
			wc_q       <= '0;
			len_q      <= '0;
			first_q    <= 1'b1;
			key_seed_q <= '0;
			key_open_q <= 1'b0;
		end else if (accept) begin
			if (job_push) begin
				pos_q <= '0;
				wa_q  <= '0;
				wb_q  <= '0;
				wc_q  <= '0;
			end else begin
				pos_q <= pos_q + {3'd0, has_byte};
				wa_q  <= wa_n;
				wb_q  <= wb_n;
				wc_q  <= wc_n;
			end
			len_q   <= in_word.last_byte ? '0 : len_n;
			first_q <= in_word.last_byte ? 1'b1 : (job_push ? 1'b0 : first_q);
			if (has_byte && !key_open_q) begin
				key_seed_q <= seed_q;
			end
			if (in_word.last_byte) begin
				key_open_q <= 1'b0;
			end else if (has_byte) begin
				key_open_q <= 1'b1;
			end
		end
	end

endmodule

[src/lkh_job_fifo.sv]
// Short job queue between the byte gatherer and the mix engine.
module lkh_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  lkh_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd,
	output logic          rd_valid,
	output lkh_pkg::job_t rd_data
);

	localparam int unsigned PTR_W = $clog2(lkh_pkg::JOB_DEPTH);
	localparam int unsigned CNT_W = $clog2(lkh_pkg::JOB_DEPTH + 1);

	lkh_pkg::job_t mem_q [lkh_pkg::JOB_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full     = (cnt_q == CNT_W'(lkh_pkg::JOB_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr && !full;
	assign do_rd    = rd && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(lkh_pkg::JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(lkh_pkg::JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/lkh_mix_back.sv]
// Back end: folds jobs into a/b/c, runs the mix one line per cycle, holds the result word.
module lkh_mix_back #(
	parameter int unsigned BUCKET_COUNT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  lkh_pkg::job_t      job,
	output logic               job_pop,
	output logic               empty,
	input  logic               pop,
	output lkh_pkg::out_word_t out_word
);

	localparam logic [31:0] BUCKET_MASK = 32'(BUCKET_COUNT - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MIX  = 4'b0010,
		S_LEN  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t      state_q;
	logic [31:0] a_q, b_q, c_q, len_q;
	logic [3:0]  rnd_q;
	logic        fin_q, again_q;
	logic        out_valid_q;
	lkh_pkg::out_word_t out_q;

	logic [31:0] base_a, base_b, base_c;
	logic [31:0] load_a, load_b, load_c;
	logic [31:0] a_mix, b_mix, c_mix;
	logic [4:0]  sh;
	logic        last_rnd, out_load;

	always_comb begin
		base_a = job.first ? lkh_pkg::GOLDEN_WORD : a_q;
		base_b = job.first ? lkh_pkg::GOLDEN_WORD : b_q;
		base_c = job.first ? job.seed : c_q;
		load_a = base_a + job.wa;
		load_b = base_b + job.wb;
		// key tail: c bytes sit one byte up, low byte takes the length
		if (job.blk) begin
			load_c = base_c + job.wc;
		end else begin
			load_c = base_c + {job.wc[23:0], 8'd0} + job.len;
		end
		sh       = lkh_pkg::mix_shift(rnd_q);
		a_mix    = (a_q - b_q - c_q) ^ (c_q >> sh);
		b_mix    = (b_q - c_q - a_q) ^ (a_q << sh);
		c_mix    = (c_q - a_q - b_q) ^ (b_q >> sh);
		last_rnd = (rnd_q == 4'(lkh_pkg::MIX_ROUNDS - 1));
		job_pop  = (state_q == S_IDLE) && job_valid;
		out_load = (state_q == S_DONE) && (!out_valid_q || pop);
	end

	assign empty    = !out_valid_q;
	assign out_word = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q   <= '0;
			fin_q   <= 1'b0;
			again_q <= 1'b0;
			len_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						a_q     <= load_a;
						b_q     <= load_b;
						c_q     <= load_c;
						len_q   <= job.len;
						fin_q   <= job.fin;
						again_q <= job.blk && job.fin;
						rnd_q   <= '0;
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					case (lkh_pkg::mix_target(rnd_q))
						lkh_pkg::TGT_A: a_q <= a_mix;
						lkh_pkg::TGT_B: b_q <= b_mix;
						lkh_pkg::TGT_C: c_q <= c_mix;
						default:        c_q <= c_q;
					endcase
					rnd_q <= rnd_q + 1'b1;
					if (last_rnd) begin
						if (again_q) begin
							state_q <= S_LEN;
						end else if (fin_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_LEN: begin
					// key ended on a block boundary: empty tail, length only
					c_q     <= c_q + len_q;
					again_q <= 1'b0;
					rnd_q   <= '0;
					state_q <= S_MIX;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.hash_value   <= c_q;
			out_q.bucket_index <= 8'(c_q & BUCKET_MASK);
		end
	end

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MIX |-> rnd_q <= 4'(lkh_pkg::MIX_ROUNDS - 1))
		else $error("mix round counter out of range");

	a_len_to_mix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LEN |=> state_q == S_MIX && rnd_q == '0)
		else $error("length add not followed by fresh mix");

	a_job_start: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> state_q == S_MIX && rnd_q == '0)
		else $error("job taken without starting mix");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_q))
		else $error("waiting result word changed");

endmodule

[src/lookup2_key_hash_core.sv]
// Top level of the streaming lookup2 key hash with bucket index.
// Throughput: one byte per cycle while the job queue is not full; the single mix unit
// works through its jobs one at a time, each 12-byte block and each key end in turn.
// Reset: arst_n clears queue, mix sequencer and seed (0); words reload per key.
module lookup2_key_hash_core #(
	parameter int unsigned BUCKET_COUNT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  lkh_pkg::in_word_t  in_word,
	output logic               empty,
	input  logic               pop,
	output lkh_pkg::out_word_t out_word,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data
);

	logic          q_full, job_push, job_valid, job_pop;
	lkh_pkg::job_t job_in, job_out;

	assign full = q_full;

	lkh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.in_word     (in_word),
		.q_full      (q_full),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.job_push    (job_push),
		.job         (job_in)
	);

	lkh_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (job_push),
		.wr_data  (job_in),
		.full     (q_full),
		.rd       (job_pop),
		.rd_valid (job_valid),
		.rd_data  (job_out)
	);

	lkh_mix_back #(
		.BUCKET_COUNT (BUCKET_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job         (job_out),
		.job_pop     (job_pop),
		.empty       (empty),
		.pop         (pop),
		.out_word    (out_word)
	);

endmodule
